### src/vca_pkg.sv
`default_nettype none
// ============================================================================
// vca_pkg
// shared types and constants of the voxel corner averager
// ============================================================================
package vca_pkg;

    // default sizes of the plane stores and of the sample port
    localparam int MAX_CELLS_X_DEF = 255;
    localparam int MAX_CELLS_Y_DEF = 255;
    localparam int SAMPLE_BITS_DEF = 16;

    // field widths
    localparam int POS_XY_W   = 8;
    localparam int POS_Z_W    = 16;
    localparam int MAXS_W     = 16;
    localparam int CELL_W     = 17;
    localparam int SUM_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CLAMP_W    = 13;

    // fixed point constants
    localparam logic [CELL_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [SUM_W-1:0]  HALF_Q19 = 20'd262144;
    localparam logic [SUM_W-1:0]  NUDGE    = 20'd52;

    // serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;

    // neighbor taps read from the plane store
    localparam int TAP_COUNT = 4;
    localparam int TAP_CNT_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELLS_X    = 3'd0,
        CFG_CELLS_Y    = 3'd1,
        CFG_CELLS_Z    = 3'd2,
        CFG_MAX_SAMPLE = 3'd3,
        CFG_PAD_VALUE  = 3'd4
    } cfg_index_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SUM,
        ST_EMIT
    } vca_state_t;

    // one plane store entry: previous layer cell and current layer cell
    typedef struct packed {
        logic [CELL_W-1:0] prev;
        logic [CELL_W-1:0] cur;
    } plane_word_t;

endpackage
`default_nettype wire

### src/vca_plane_ram.sv
`default_nettype none
// ============================================================================
// vca_plane_ram
// plane store, one write port and one registered read port
// ============================================================================
module vca_plane_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire vca_pkg::plane_word_t wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output vca_pkg::plane_word_t     rd_data
);

    vca_pkg::plane_word_t mem [DEPTH];
    vca_pkg::plane_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### src/vca_serial_div.sv
`default_nettype none
// ============================================================================
// vca_serial_div
// restoring divider, one quotient bit per cycle, numer <= denom assumed
// ============================================================================
module vca_serial_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [vca_pkg::CELL_W-1:0]   numer,
    input  wire logic [vca_pkg::MAXS_W-1:0]   denom,
    output logic                              busy,
    output logic                              finish,
    output logic [vca_pkg::CELL_W-1:0]        quotient
);

    logic [vca_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic [vca_pkg::CELL_W-1:0]    rem_reg;
    logic [vca_pkg::CELL_W-1:0]    rem_next;
    logic [vca_pkg::CELL_W-1:0]    quo_reg;
    logic [vca_pkg::CELL_W-1:0]    quo_next;
    logic [vca_pkg::CELL_W-1:0]    cand;
    logic [vca_pkg::CELL_W-1:0]    denom_ext;
    logic                          ge;

    // first step compares the numerator itself (quotient bit 16)
    always_comb
    begin
        denom_ext = {1'b0, denom};
        cand      = (cnt_reg == '0) ? rem_reg : {rem_reg[vca_pkg::CELL_W-2:0], 1'b0};
        ge        = (cand >= denom_ext);
        rem_next  = ge ? (cand - denom_ext) : cand;
        quo_next  = {quo_reg[vca_pkg::CELL_W-2:0], ge};
    end

    assign finish   = busy_reg && (cnt_reg == vca_pkg::DIV_CNT_W'(vca_pkg::DIV_STEPS - 1));
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (finish)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule
`default_nettype wire

### src/voxel_corner_averager.sv
`default_nettype none
// ============================================================================
// voxel_corner_averager
// cell to vertex averaging over a 2x2x2 neighborhood of normalized samples
// ============================================================================
// usage
//   - samples stream in raster order (x fastest, then y, then z) over the
//     extended grid of (cells_x+1)(cells_y+1)(cells_z+1) positions; filler
//     positions still need a transaction, their sample is ignored
//   - every input transaction gives exactly one output transaction carrying
//     vertex_value (q1.19 mean), sample_error and last
//   - configuration goes through the cfg channel, always ready; write it
//     only while no transaction is in flight
//   - an item passes through the accept step, the serial divider (one
//     quotient bit per cycle), the sum step that adds the new cell and
//     updates the plane store, and the emit step that loads the output
//     register; the four neighbor reads of the plane store overlap the divider
//   - in_ready is high only while the sequencer is idle
//   - a stalled receiver holds the item in the emit step until the output
//     register frees up; one finished result waits there meanwhile
//   - reset returns the position counters and configuration registers to their defaults;
//     the plane store is not cleared, entries read before written are
//     undefined
// ============================================================================
module voxel_corner_averager #(
    parameter int MAX_CELLS_X = vca_pkg::MAX_CELLS_X_DEF,
    parameter int MAX_CELLS_Y = vca_pkg::MAX_CELLS_Y_DEF,
    parameter int SAMPLE_BITS = vca_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input transactions
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [SAMPLE_BITS-1:0]            sample,
    // output transactions
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [vca_pkg::SUM_W-1:0]              vertex_value,
    output logic                                   sample_error,
    output logic                                   last,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vca_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // plane store geometry
    localparam int PLANE_W    = MAX_CELLS_X + 1;
    localparam int PLANE_SIZE = PLANE_W * (MAX_CELLS_Y + 1);
    localparam int ADDR_W     = (PLANE_SIZE > 1) ? $clog2(PLANE_SIZE) : 1;
    // width for the saturation compare
    localparam int CMP_W      = (SAMPLE_BITS > vca_pkg::MAXS_W) ? SAMPLE_BITS : vca_pkg::MAXS_W;

    localparam int XYW = vca_pkg::POS_XY_W;
    localparam int ZW  = vca_pkg::POS_Z_W;
    localparam int CW  = vca_pkg::CELL_W;
    localparam int SW  = vca_pkg::SUM_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [XYW-1:0]              cells_x_reg;
    logic [XYW-1:0]              cells_y_reg;
    logic [ZW-1:0]               cells_z_reg;
    logic [vca_pkg::MAXS_W-1:0]  max_sample_reg;
    logic [CW-1:0]               pad_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg    <= XYW'(1);
            cells_y_reg    <= XYW'(1);
            cells_z_reg    <= ZW'(1);
            max_sample_reg <= '1;
            pad_value_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (vca_pkg::cfg_index_t'(cfg_index))
                vca_pkg::CFG_CELLS_X:    cells_x_reg    <= cfg_data[XYW-1:0];
                vca_pkg::CFG_CELLS_Y:    cells_y_reg    <= cfg_data[XYW-1:0];
                vca_pkg::CFG_CELLS_Z:    cells_z_reg    <= cfg_data[ZW-1:0];
                vca_pkg::CFG_MAX_SAMPLE: max_sample_reg <= cfg_data[vca_pkg::MAXS_W-1:0];
                vca_pkg::CFG_PAD_VALUE:  pad_value_reg  <= cfg_data[CW-1:0];
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // effective counts, pad and wrapped positions
    // ------------------------------------------------------------------
    logic [XYW-1:0] cx, cy;
    logic [ZW-1:0]  cz;
    logic [CW-1:0]  pad;
    logic [XYW-1:0] pos_x_reg, pos_y_reg;
    logic [ZW-1:0]  pos_z_reg;
    logic [XYW-1:0] xw, yw, xm, ym;
    logic [ZW-1:0]  zw;
    logic           filler;
    logic           last_now;

    always_comb
    begin
        // counts beyond the store size clamp to it
        cx  = (vca_pkg::CLAMP_W'(cells_x_reg) > vca_pkg::CLAMP_W'(MAX_CELLS_X))
            ? XYW'(MAX_CELLS_X) : cells_x_reg;
        cy  = (vca_pkg::CLAMP_W'(cells_y_reg) > vca_pkg::CLAMP_W'(MAX_CELLS_Y))
            ? XYW'(MAX_CELLS_Y) : cells_y_reg;
        cz  = cells_z_reg;
        pad = (pad_value_reg > vca_pkg::ONE_Q16) ? vca_pkg::ONE_Q16 : pad_value_reg;
        // a counter beyond a shrunk count restarts at zero
        xw  = (pos_x_reg > cx) ? '0 : pos_x_reg;
        yw  = (pos_y_reg > cy) ? '0 : pos_y_reg;
        zw  = (pos_z_reg > cz) ? '0 : pos_z_reg;
        xm  = (xw == '0) ? '0 : xw - 1'b1;
        ym  = (yw == '0) ? '0 : yw - 1'b1;
        filler   = (xw == cx) || (yw == cy) || (zw == cz);
        last_now = (xw == cx) && (yw == cy) && (zw == cz);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    vca_pkg::vca_state_t state_reg, state_next;

    logic                  div_start;
    logic                  div_busy;
    logic                  div_finish;
    logic [CW-1:0]         div_quotient;
    logic                  issue_rd;
    logic                  mem_we;
    logic                  emit_load;
    logic                  out_valid_reg;
    logic [vca_pkg::TAP_CNT_W-1:0] tap_cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vca_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vca_pkg::ST_DIVIDE;
                end
            end
            vca_pkg::ST_DIVIDE:
            begin
                if (div_finish)
                begin
                    state_next = vca_pkg::ST_SUM;
                end
            end
            vca_pkg::ST_SUM:
            begin
                state_next = vca_pkg::ST_EMIT;
            end
            vca_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = vca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vca_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == vca_pkg::ST_IDLE);
        div_start = (state_reg == vca_pkg::ST_IDLE) && in_valid;
        issue_rd  = (state_reg == vca_pkg::ST_DIVIDE)
                 && (tap_cnt_reg < vca_pkg::TAP_CNT_W'(vca_pkg::TAP_COUNT));
        mem_we    = (state_reg == vca_pkg::ST_SUM);
        emit_load = (state_reg == vca_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vca_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // normalization: floor(sample * 65536 / max_sample) in the divider
    // ------------------------------------------------------------------
    logic sat_reg;
    logic zero_reg;

    vca_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (CW'(sample)),
        .denom    (max_sample_reg),
        .busy     (div_busy),
        .finish   (div_finish),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            sat_reg  <= (CMP_W'(sample) > CMP_W'(max_sample_reg));
            zero_reg <= (sample == '0);
        end
    end

    // ------------------------------------------------------------------
    // plane store: each entry holds the previous and current layer cell
    // taps: 0 self, 1 left (x-1), 2 front (y-1), 3 corner (x-1, y-1)
    // ------------------------------------------------------------------
    logic [XYW-1:0]          tap_x, tap_y;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    vca_pkg::plane_word_t    rd_data;
    vca_pkg::plane_word_t    wr_data;
    logic                    rd_pend_reg;
    logic [1:0]              rd_tap_reg;
    logic [CW-1:0]           oldcur_reg;
    logic [CW-1:0]           new_cell;

    always_comb
    begin
        tap_x   = tap_cnt_reg[0] ? xm : xw;
        tap_y   = tap_cnt_reg[1] ? ym : yw;
        rd_addr = ADDR_W'(ADDR_W'(tap_y) * ADDR_W'(PLANE_W)) + ADDR_W'(tap_x);
        wr_addr = ADDR_W'(ADDR_W'(yw) * ADDR_W'(PLANE_W)) + ADDR_W'(xw);
        wr_data = '{prev: oldcur_reg, cur: new_cell};
    end

    vca_plane_ram #(
        .DEPTH  (PLANE_SIZE),
        .ADDR_W (ADDR_W)
    ) u_plane (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (div_start)
            begin
                tap_cnt_reg <= '0;
            end
            else if (issue_rd)
            begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
            end
            rd_pend_reg <= issue_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tap_reg <= tap_cnt_reg[1:0];
    end

    // ------------------------------------------------------------------
    // neighbor accumulation as read data returns
    // ------------------------------------------------------------------
    logic          tap_out;
    logic          z_first;
    logic [CW-1:0] add_a, add_b;
    logic [SW-1:0] acc_reg;
    logic [SW-1:0] sum_reg;
    logic          err_reg;

    always_comb
    begin
        // left or front of the volume edge reads as pad
        tap_out = (rd_tap_reg[0] && (xw == '0)) || (rd_tap_reg[1] && (yw == '0));
        z_first = (zw == '0);
        if (rd_tap_reg == 2'd0)
        begin
            // self: the new cell is added later, old current is now previous
            add_a = '0;
            add_b = z_first ? pad : rd_data.cur;
        end
        else
        begin
            add_a = tap_out ? pad : rd_data.cur;
            add_b = (tap_out || z_first) ? pad : rd_data.prev;
        end
        if (filler)
        begin
            new_cell = pad;
        end
        else if (sat_reg)
        begin
            new_cell = vca_pkg::ONE_Q16;
        end
        else if (zero_reg)
        begin
            new_cell = '0;
        end
        else
        begin
            new_cell = div_quotient;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            acc_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            acc_reg <= acc_reg + SW'(add_a) + SW'(add_b);
        end
        if (rd_pend_reg && (rd_tap_reg == 2'd0))
        begin
            oldcur_reg <= rd_data.cur;
        end
        if (mem_we)
        begin
            sum_reg <= acc_reg + SW'(new_cell);
            err_reg <= !filler && sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // push the mean out of the band around one half, output register
    // ------------------------------------------------------------------
    logic [SW-1:0] nudged;
    logic [SW-1:0] vertex_value_reg;
    logic          sample_error_reg;
    logic          last_reg;

    always_comb
    begin
        if ((sum_reg > (vca_pkg::HALF_Q19 - vca_pkg::NUDGE)) && (sum_reg <= vca_pkg::HALF_Q19))
        begin
            nudged = vca_pkg::HALF_Q19 - vca_pkg::NUDGE;
        end
        else if ((sum_reg > vca_pkg::HALF_Q19)
                 && (sum_reg < (vca_pkg::HALF_Q19 + vca_pkg::NUDGE)))
        begin
            nudged = vca_pkg::HALF_Q19 + vca_pkg::NUDGE;
        end
        else
        begin
            nudged = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            vertex_value_reg <= nudged;
            sample_error_reg <= err_reg;
            last_reg         <= last_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_value = vertex_value_reg;
    assign sample_error = sample_error_reg;
    assign last         = last_reg;

    // ------------------------------------------------------------------
    // raster position, advanced once the result is loaded
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else if (emit_load)
        begin
            if (xw >= cx)
            begin
                pos_x_reg <= '0;
                if (yw >= cy)
                begin
                    pos_y_reg <= '0;
                    pos_z_reg <= (zw >= cz) ? '0 : zw + 1'b1;
                end
                else
                begin
                    pos_y_reg <= yw + 1'b1;
                    pos_z_reg <= zw;
                end
            end
            else
            begin
                pos_x_reg <= xw + 1'b1;
                pos_y_reg <= yw;
                pos_z_reg <= zw;
            end
        end
    end

`ifndef SYNTHESIS
    // all four neighbor reads are back before the sum step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vca_pkg::ST_SUM)
        |-> (tap_cnt_reg == vca_pkg::TAP_CNT_W'(vca_pkg::TAP_COUNT)) && !rd_pend_reg)
    else $error("plane reads still outstanding at sum step");

    // the divider only runs while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == vca_pkg::ST_DIVIDE))
    else $error("divider busy outside divide step");

    // a held result never sits inside the band around one half
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg
        |-> !((vertex_value_reg > (vca_pkg::HALF_Q19 - vca_pkg::NUDGE))
              && (vertex_value_reg < (vca_pkg::HALF_Q19 + vca_pkg::NUDGE))))
    else $error("vertex value inside the half band");

    // the final vertex restarts the raster
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && last_now)
        |=> (pos_x_reg == '0) && (pos_y_reg == '0) && (pos_z_reg == '0))
    else $error("raster position not restarted after last vertex");
`endif

endmodule
`default_nettype wire

### verif/tb_voxel_corner_averager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voxel_corner_averager
// self-checking bench: whole volumes of raster-ordered samples go through the
// block under several register settings; a local model of the plane stores
// and of the 2x2x2 corner sum predicts every vertex, and each output
// transaction is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_voxel_corner_averager;

    // plane store geometry as seen by the model
    localparam int unsigned PLANE_W     = vca_pkg::MAX_CELLS_X_DEF + 1;
    localparam int unsigned PLANE_WORDS = (vca_pkg::MAX_CELLS_X_DEF + 1)
                                        * (vca_pkg::MAX_CELLS_Y_DEF + 1);
    // items queued per random phase
    localparam int unsigned PHASE_ITEMS = 200;
    // a limit well above one item plus a receiver stall run; reaching it
    // with no transaction on any channel means the block is stuck
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    // cycles to watch for stray output transactions after the last one
    localparam int unsigned DRAIN_CYCLES = 40;
    // keep the log readable on a badly broken block
    localparam int unsigned MAX_REPORTS = 50;

    // one full register setting for a volume
    typedef struct packed {
        logic [7:0]  cells_x;
        logic [7:0]  cells_y;
        logic [15:0] cells_z;
        logic [15:0] max_sample;
        logic [16:0] pad_value;
    } volume_cfg_t;

    // fields of one predicted output transaction
    typedef struct packed {
        logic [vca_pkg::SUM_W-1:0] vertex_value;
        logic                      sample_error;
        logic                      is_last;
    } vertex_result_t;

    // block ports, all inputs known from time zero
    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [vca_pkg::SAMPLE_BITS_DEF-1:0]  sample = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [vca_pkg::SUM_W-1:0]            vertex_value;
    logic                                 sample_error;
    logic                                 last;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    vca_pkg::cfg_index_t                  cfg_index = vca_pkg::CFG_CELLS_X;
    logic [vca_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    // samples waiting for the input driver, predictions waiting for results
    logic [vca_pkg::SAMPLE_BITS_DEF-1:0]  pending_samples[$];
    vertex_result_t                       expected_vertices[$];

    // idling percentages, changed per phase
    int unsigned sender_idle_pct = 19;
    int unsigned receiver_stall_pct = 46;

    int unsigned mismatches = 0;
    int unsigned queued_items = 0;
    int unsigned quiet_cycles = 0;

    // model copy of the registers, at their reset values
    int unsigned model_cells_x = 1;
    int unsigned model_cells_y = 1;
    int unsigned model_cells_z = 1;
    int unsigned model_max_sample = 65535;
    int unsigned model_pad_value = 0;

    // model copy of the plane stores and the raster position
    logic [vca_pkg::CELL_W-1:0] prev_plane [PLANE_WORDS];
    logic [vca_pkg::CELL_W-1:0] cur_plane [PLANE_WORDS];
    int unsigned vx = 0;
    int unsigned vy = 0;
    int unsigned vz = 0;

    voxel_corner_averager u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_value (vertex_value),
        .sample_error (sample_error),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------

    function automatic int unsigned plane_cell(input bit from_prev, input int unsigned x,
                                               input int unsigned y);
        int unsigned addr;
        addr = (y * PLANE_W + x) % PLANE_WORDS;
        return from_prev ? int'(prev_plane[addr]) : int'(cur_plane[addr]);
    endfunction

    // four cells of one layer around the vertex, pad where x-1 or y-1 falls off
    function automatic int unsigned corner_sum(input bit from_prev, input int unsigned x,
                                               input int unsigned y, input int unsigned pad);
        int unsigned total;
        total = plane_cell(from_prev, x, y);
        total += (x == 0) ? pad : plane_cell(from_prev, x - 1, y);
        total += (y == 0) ? pad : plane_cell(from_prev, x, y - 1);
        total += (x == 0 || y == 0) ? pad : plane_cell(from_prev, x - 1, y - 1);
        return total;
    endfunction

    // one accepted sample: update the planes, queue the expected vertex
    function automatic void predict_vertex(input logic [vca_pkg::SAMPLE_BITS_DEF-1:0] raw);
        int unsigned cx;
        int unsigned cy;
        int unsigned cz;
        int unsigned pad;
        int unsigned smp;
        int unsigned cell_value;
        int unsigned total;
        int unsigned addr;
        bit          filler;
        bit          saturated;
        vertex_result_t res;
        cx = (model_cells_x > vca_pkg::MAX_CELLS_X_DEF) ? vca_pkg::MAX_CELLS_X_DEF
                                                          : model_cells_x;
        cy = (model_cells_y > vca_pkg::MAX_CELLS_Y_DEF) ? vca_pkg::MAX_CELLS_Y_DEF
                                                          : model_cells_y;
        cz = model_cells_z;
        pad = (model_pad_value > vca_pkg::ONE_Q16) ? vca_pkg::ONE_Q16 : model_pad_value;
        smp = raw;
        if (vx > cx) vx = 0;
        if (vy > cy) vy = 0;
        if (vz > cz) vz = 0;

        // filler positions take the pad and never flag
        filler = (vx == cx) || (vy == cy) || (vz == cz);
        saturated = 1'b0;
        if (filler)
            cell_value = pad;
        else if (smp > model_max_sample)
        begin
            cell_value = vca_pkg::ONE_Q16;
            saturated = 1'b1;
        end
        else if (model_max_sample == 0)
            cell_value = 0;
        else
            cell_value = (smp << 16) / model_max_sample;

        addr = (vy * PLANE_W + vx) % PLANE_WORDS;
        prev_plane[addr] = cur_plane[addr];
        cur_plane[addr] = cell_value;

        // bottom layer sees pad below it
        total = corner_sum(1'b0, vx, vy, pad)
              + ((vz == 0) ? 4 * pad : corner_sum(1'b1, vx, vy, pad));

        // push a mean near one half out to the nudge distance
        if (total <= vca_pkg::HALF_Q19)
        begin
            if (vca_pkg::HALF_Q19 - total < vca_pkg::NUDGE)
                total = vca_pkg::HALF_Q19 - vca_pkg::NUDGE;
        end
        else if (total - vca_pkg::HALF_Q19 < vca_pkg::NUDGE)
            total = vca_pkg::HALF_Q19 + vca_pkg::NUDGE;

        res.vertex_value = vca_pkg::SUM_W'(total);
        res.sample_error = saturated;
        res.is_last = (vx == cx) && (vy == cy) && (vz == cz);
        expected_vertices.push_back(res);

        // raster advance, wrapping to a new volume after the last vertex
        if (vx >= cx)
        begin
            vx = 0;
            if (vy >= cy)
            begin
                vy = 0;
                vz = (vz >= cz) ? 0 : vz + 1;
            end
            else
                vy = vy + 1;
        end
        else
            vx = vx + 1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic volume_cfg_t make_cfg(input int unsigned x, input int unsigned y,
                                             input int unsigned z, input int unsigned maxs,
                                             input int unsigned pad);
        volume_cfg_t c;
        c.cells_x = 8'(x);
        c.cells_y = 8'(y);
        c.cells_z = 16'(z);
        c.max_sample = 16'(maxs);
        c.pad_value = 17'(pad);
        return c;
    endfunction

    // raw sample: near one half in near_half mode, else edges around max_sample, field extremes, or uniform
    function automatic logic [15:0] pick_sample(input volume_cfg_t c, input bit near_half);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (near_half)
            return 16'(32768 + $urandom_range(0, 40) - 20);
        case (r)
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return c.max_sample;
            3: return c.max_sample + 16'd1;
            4, 5, 6: return 16'($urandom_range(0, c.max_sample));
            default: return 16'($urandom);
        endcase
    endfunction

    // random volume shape and scaling; near_half keeps cells around 0.5 so
    // that corner sums land on both sides of the nudge band
    task automatic pick_volume(output volume_cfg_t c, output bit near_half);
        int unsigned shape;
        shape = $urandom_range(0, 99);
        c.cells_x = 8'($urandom_range(1, 5));
        c.cells_y = 8'($urandom_range(1, 4));
        c.cells_z = 16'($urandom_range(1, 3));
        if (shape < 12)
        begin
            // zero count: the whole axis is filler
            case ($urandom_range(0, 2))
                0: c.cells_x = 8'd0;
                1: c.cells_y = 8'd0;
                default: c.cells_z = 16'd0;
            endcase
        end
        else if (shape < 20)
        begin
            c.cells_x = 8'($urandom_range(6, 60));
            c.cells_y = 8'($urandom_range(1, 2));
            c.cells_z = 16'd1;
        end
        else if (shape < 26)
        begin
            c.cells_y = 8'($urandom_range(5, 30));
            c.cells_z = 16'd1;
        end

        near_half = ($urandom_range(0, 4) == 0);
        if (near_half)
        begin
            c.max_sample = 16'hFFFF;
            c.pad_value = 17'd32768;
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: c.max_sample = 16'($urandom_range(0, 3));
                1: c.max_sample = 16'hFFFF;
                default: c.max_sample = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 5))
                0: c.pad_value = 17'd0;
                1: c.pad_value = 17'd65536;
                2: c.pad_value = 17'($urandom_range(65537, 131071));
                default: c.pad_value = 17'($urandom_range(0, 65536));
            endcase
        end
    endtask

    // block idle: nothing queued, nothing presented, nothing outstanding;
    // checked between edges so the driver's updates have settled, then
    // realigned to a rising edge
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_vertices.size() != 0);
        @(posedge clk);
    endtask

    // write all five registers back to back, valid held high throughout
    task automatic load_config(input volume_cfg_t c);
        vca_pkg::cfg_index_t            order [5];
        vca_pkg::cfg_index_t            idx;
        logic [vca_pkg::CFG_DATA_W-1:0] value;
        order = '{vca_pkg::CFG_CELLS_X, vca_pkg::CFG_CELLS_Y, vca_pkg::CFG_CELLS_Z,
                  vca_pkg::CFG_MAX_SAMPLE, vca_pkg::CFG_PAD_VALUE};
        for (int i = 0; i < 5; i++)
        begin
            idx = order[i];
            case (idx)
                vca_pkg::CFG_CELLS_X:    value = vca_pkg::CFG_DATA_W'(c.cells_x);
                vca_pkg::CFG_CELLS_Y:    value = vca_pkg::CFG_DATA_W'(c.cells_y);
                vca_pkg::CFG_CELLS_Z:    value = vca_pkg::CFG_DATA_W'(c.cells_z);
                vca_pkg::CFG_MAX_SAMPLE: value = vca_pkg::CFG_DATA_W'(c.max_sample);
                default:                 value = c.pad_value;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            // register write taken on this edge
            case (idx)
                vca_pkg::CFG_CELLS_X:    model_cells_x = value;
                vca_pkg::CFG_CELLS_Y:    model_cells_y = value;
                vca_pkg::CFG_CELLS_Z:    model_cells_z = value;
                vca_pkg::CFG_MAX_SAMPLE: model_max_sample = value;
                default:                 model_pad_value = value;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // whole volumes only, so counts never change in the middle of one
    task automatic queue_volumes(input volume_cfg_t c, input bit near_half,
                                 input int unsigned count);
        int unsigned n;
        n = (int'(c.cells_x) + 1) * (int'(c.cells_y) + 1) * (int'(c.cells_z) + 1) * count;
        repeat (n)
            pending_samples.push_back(pick_sample(c, near_half));
        queued_items += n;
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    // ------------------------------------------------------------------
    // input driver: presents queued samples, predicts on each transaction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_vertex(sample);
            // free slot: load the next sample unless the sender idles this cycle
            if ((!in_valid || in_ready) && pending_samples.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                sample <= pending_samples.pop_front();
            end
            else if (in_valid && in_ready)
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output monitor: random backpressure, in-order field compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        vertex_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            if (out_valid && out_ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected vertex transaction, vertex_value %0d", vertex_value);
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (vertex_value !== want.vertex_value)
                        report_mismatch("vertex_value", want.vertex_value, vertex_value);
                    if (sample_error !== want.sample_error)
                        report_mismatch("sample_error", want.sample_error, sample_error);
                    if (last !== want.is_last)
                        report_mismatch("last", want.is_last, last);
                end
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("voxel_corner_averager: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        volume_cfg_t c;
        bit          near_half;
        int unsigned phase_start;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: a lone real cell at exactly one half with pad one half,
        // so the corner sum sits on 262144 and must be nudged down
        wait_idle();
        load_config(make_cfg(1, 1, 1, 65535, 32768));
        pending_samples.push_back(16'd32768);
        repeat (7) pending_samples.push_back(16'($urandom));

        // directed: zero max_sample (zero stays zero, anything else saturates),
        // pad above one, sample field extremes
        wait_idle();
        load_config(make_cfg(3, 1, 1, 0, 131071));
        pending_samples.push_back(16'd0);
        pending_samples.push_back(16'd1);
        pending_samples.push_back(16'hFFFF);
        repeat (13) pending_samples.push_back(16'($urandom));

        // three phases of idling: sender light / receiver heavy, swapped, none
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 19;
                    receiver_stall_pct = 46;
                end
                1:
                begin
                    sender_idle_pct = 46;
                    receiver_stall_pct = 19;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase

            // one long all-filler run per phase: widest x, widest y, then a
            // tall column that runs the layer counter up to 255
            wait_idle();
            pick_volume(c, near_half);
            case (phase)
                0:
                begin
                    c.cells_x = 8'd255;
                    c.cells_y = 8'd0;
                    c.cells_z = 16'd0;
                end
                1:
                begin
                    c.cells_x = 8'd0;
                    c.cells_y = 8'd255;
                    c.cells_z = 16'd0;
                end
                default:
                begin
                    c.cells_x = 8'd0;
                    c.cells_y = 8'd0;
                    c.cells_z = 16'd255;
                end
            endcase
            load_config(c);
            queue_volumes(c, near_half, 1);

            // random small volumes, sometimes two back to back
            phase_start = queued_items;
            while (queued_items - phase_start < PHASE_ITEMS)
            begin
                pick_volume(c, near_half);
                wait_idle();
                load_config(c);
                queue_volumes(c, near_half, $urandom_range(1, 2));
            end
        end

        // drain, then watch a little longer for stray output transactions
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("voxel_corner_averager: match");
        else
            $display("voxel_corner_averager: mismatch");
        $finish;
    end

endmodule

### files.f
src/vca_pkg.sv
src/vca_plane_ram.sv
src/vca_serial_div.sv
src/voxel_corner_averager.sv
verif/tb_voxel_corner_averager.sv
